[rtl/dscq_pkg.sv]
// Shared types and constants for the dial settle and chatter qualifier.
// Holds action codes, register indexes, reset values and the result word layout.
// No dependencies.
package dscq_pkg;

  // Action codes carried in the input word's tuser
  typedef enum logic [2:0] {
    ACT_SET_BANK   = 3'd0,
    ACT_DIAL       = 3'd1,
    ACT_SET_PAUSE  = 3'd2,
    ACT_SNAPSHOT   = 3'd3,
    ACT_SELECT_NOW = 3'd4,
    ACT_TICK       = 3'd5
  } action_t;

  // Configuration register indexes
  localparam logic [1:0] REG_SETTLE       = 2'd0;
  localparam logic [1:0] REG_SWEEP_SETTLE = 2'd1;
  localparam logic [1:0] REG_SWEEP_WINDOW = 2'd2;
  localparam logic [1:0] REG_CHATTER_SPAN = 2'd3;

  localparam int CfgIndexWidth = 2;
  localparam int CfgDataWidth  = 16;

  // Register reset values
  localparam logic [15:0] SETTLE_RST       = 16'd1000;
  localparam logic [15:0] SWEEP_SETTLE_RST = 16'd2000;
  localparam logic [15:0] SWEEP_WINDOW_RST = 16'd2000;
  localparam logic [7:0]  CHATTER_SPAN_RST = 8'd1;

  // ASCII range folded to upper case
  localparam logic [7:0] LOWER_A   = 8'h61;
  localparam logic [7:0] LOWER_Z   = 8'h7a;
  localparam logic [7:0] CASE_STEP = 8'h20;

  localparam int InDataWidth  = 56;   // 49 field bits, padded to bytes
  localparam int OutDataWidth = 120;  // 118 field bits, padded to bytes

  // Result word, first field in the highest bits
  typedef struct packed {
    logic [31:0] reading_total;
    logic [31:0] ignored_total;
    logic [31:0] apply_total;
    logic        settling;
    logic        chatter_active;
    logic        restart_forced;
    logic        tuned;
    logic        out_paused;
    logic [7:0]  out_position;
    logic [7:0]  out_bank;
    logic        applied_now;
  } result_t;

endpackage

[rtl/dial_settle_chatter_qualifier.sv]
// Dial settle and chatter qualifier: top level, single module.
// Depends on dscq_pkg for action codes, register indexes and the result layout.
// The result word is registered and appears in the cycle after its input word is accepted.
// Throughput: one word per cycle; the input side stalls only while the result
// register holds a word that the output side has not taken.
// Reset (rst, synchronous, active high) clears all qualifier state and counters
// and loads the configuration registers with their default values.
module dial_settle_chatter_qualifier (
  input  logic                                  clk,
  input  logic                                  rst,
  // Configuration write port
  input  logic                                  cfg_wr_en,
  input  logic [dscq_pkg::CfgIndexWidth-1:0]    cfg_index,
  input  logic [dscq_pkg::CfgDataWidth-1:0]     cfg_data,
  // Input stream
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // tdata: now_ms[31:0], bank_code[39:32], dial_position[47:40],
  //        pause_request[48], zero pad [55:49]
  input  logic [dscq_pkg::InDataWidth-1:0]      s_tdata,
  // tuser: action[2:0]
  input  logic [2:0]                            s_tuser,
  // Output stream
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // tdata: applied_now[0], out_bank[8:1], out_position[16:9], out_paused[17],
  //        tuned[18], restart_forced[19], chatter_active[20], settling[21],
  //        apply_total[53:22], ignored_total[85:54], reading_total[117:86],
  //        zero pad [119:118]
  output logic [dscq_pkg::OutDataWidth-1:0]     m_tdata
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [15:0] settle_ms;
  logic [15:0] sweep_settle_ms;
  logic [15:0] sweep_window_ms;
  logic [7:0]  chatter_span;

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_ms       <= dscq_pkg::SETTLE_RST;
      sweep_settle_ms <= dscq_pkg::SWEEP_SETTLE_RST;
      sweep_window_ms <= dscq_pkg::SWEEP_WINDOW_RST;
      chatter_span    <= dscq_pkg::CHATTER_SPAN_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        dscq_pkg::REG_SETTLE:       settle_ms       <= cfg_data;
        dscq_pkg::REG_SWEEP_SETTLE: sweep_settle_ms <= cfg_data;
        dscq_pkg::REG_SWEEP_WINDOW: sweep_window_ms <= cfg_data;
        dscq_pkg::REG_CHATTER_SPAN: chatter_span    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Qualifier state
  // ---------------------------------------------------------------------------
  logic        have_desired, have_desired_next;
  logic [7:0]  desired_bank, desired_bank_next;
  logic [7:0]  desired_position, desired_position_next;
  logic        desired_pause, desired_pause_next;
  logic        have_applied, have_applied_next;
  logic [7:0]  applied_bank, applied_bank_next;
  logic [7:0]  applied_position, applied_position_next;
  logic        applied_pause, applied_pause_next;
  logic [31:0] deadline, deadline_next;
  logic        have_reading_time, have_reading_time_next;
  logic [31:0] last_reading_time, last_reading_time_next;
  logic        have_last, have_last_next;
  logic        have_previous, have_previous_next;
  logic [7:0]  last_position, last_position_next;
  logic [7:0]  previous_position, previous_position_next;
  logic        chatter_flag, chatter_flag_next;
  logic [7:0]  pair_low, pair_low_next;
  logic [7:0]  pair_high, pair_high_next;
  logic        force_restart, force_restart_next;
  logic [31:0] apply_count, apply_count_next;
  logic [31:0] ignore_count, ignore_count_next;
  logic [31:0] reading_count, reading_count_next;

  // Result register
  logic                out_valid;
  dscq_pkg::result_t   result, result_next;

  // ---------------------------------------------------------------------------
  // Input word unpack
  // ---------------------------------------------------------------------------
  logic [31:0] now_ms;
  logic [7:0]  bank_raw;
  logic [7:0]  bank_code;
  logic [7:0]  dial_position;
  logic        pause_request;
  logic [2:0]  action;
  logic        accept;

  assign now_ms        = s_tdata[31:0];
  assign bank_raw      = s_tdata[39:32];
  assign dial_position = s_tdata[47:40];
  assign pause_request = s_tdata[48];
  assign action        = s_tuser;

  // Take a new word whenever the result register is empty or being drained
  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // Fold lower-case bank letters to upper case
  always_comb begin
    bank_code = bank_raw;
    if (bank_raw inside {[dscq_pkg::LOWER_A:dscq_pkg::LOWER_Z]}) begin
      bank_code = bank_raw - dscq_pkg::CASE_STEP;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared compares
  // ---------------------------------------------------------------------------
  logic        pending_now;     // desired differs from applied, before this word
  logic        deadline_passed; // signed wrap compare of now against deadline
  logic [31:0] since_deadline;
  logic [31:0] since_reading;
  logic        mid_turn;        // previous reading inside the sweep window
  logic [8:0]  fwd_diff;
  logic [8:0]  back_diff;
  logic        span_hit;        // reading is chatter_span away from the last one
  logic        in_pair;
  logic        xyx_hit;

  assign pending_now = have_desired &&
                       (!have_applied || desired_bank != applied_bank ||
                        desired_position != applied_position ||
                        desired_pause != applied_pause);

  assign since_deadline  = now_ms - deadline;
  assign deadline_passed = !since_deadline[31];

  assign since_reading = now_ms - last_reading_time;
  assign mid_turn      = have_reading_time && (since_reading <= {16'd0, sweep_window_ms});

  // A negative difference never matches the span, so a 9-bit difference is enough
  assign fwd_diff  = {1'b0, last_position} - {1'b0, dial_position};
  assign back_diff = {1'b0, dial_position} - {1'b0, last_position};
  assign span_hit  = (fwd_diff == {1'b0, chatter_span}) ||
                     (back_diff == {1'b0, chatter_span});

  assign in_pair = (dial_position == pair_low) || (dial_position == pair_high);
  assign xyx_hit = have_previous && (dial_position == previous_position) && span_hit;

  // ---------------------------------------------------------------------------
  // Next state for one accepted word
  // ---------------------------------------------------------------------------
  logic applied_flag;

  always_comb begin
    have_desired_next      = have_desired;
    desired_bank_next      = desired_bank;
    desired_position_next  = desired_position;
    desired_pause_next     = desired_pause;
    have_applied_next      = have_applied;
    applied_bank_next      = applied_bank;
    applied_position_next  = applied_position;
    applied_pause_next     = applied_pause;
    deadline_next          = deadline;
    have_reading_time_next = have_reading_time;
    last_reading_time_next = last_reading_time;
    have_last_next         = have_last;
    have_previous_next     = have_previous;
    last_position_next     = last_position;
    previous_position_next = previous_position;
    chatter_flag_next      = chatter_flag;
    pair_low_next          = pair_low;
    pair_high_next         = pair_high;
    force_restart_next     = force_restart;
    apply_count_next       = apply_count;
    ignore_count_next      = ignore_count;
    reading_count_next     = reading_count;
    applied_flag           = 1'b0;

    case (action)
      dscq_pkg::ACT_SET_BANK: begin
        // Drop a bank request that repeats the desired one
        if (!(have_desired && bank_code == desired_bank)) begin
          desired_bank_next = bank_code;
          have_desired_next = 1'b1;
          deadline_next     = now_ms;
        end
      end
      dscq_pkg::ACT_DIAL: begin
        reading_count_next     = reading_count + 32'd1;
        // Every reading shifts the position history and stamps the time
        previous_position_next = last_position;
        have_previous_next     = have_last;
        last_position_next     = dial_position;
        have_last_next         = 1'b1;
        have_reading_time_next = 1'b1;
        last_reading_time_next = now_ms;
        if (chatter_flag && in_pair) begin
          // Reading bounces inside the latched pair: count it and hold the target
          ignore_count_next = ignore_count + 32'd1;
        end else begin
          chatter_flag_next = 1'b0;
          if (xyx_hit) begin
            chatter_flag_next = 1'b1;
            if (dial_position < last_position) begin
              pair_low_next  = dial_position;
              pair_high_next = last_position;
            end else begin
              pair_low_next  = last_position;
              pair_high_next = dial_position;
            end
          end
          desired_position_next = dial_position;
          have_desired_next     = 1'b1;
          // Restart the settle: long while sweeping, short for a lone reading
          deadline_next = now_ms + {16'd0, (mid_turn ? sweep_settle_ms : settle_ms)};
        end
      end
      dscq_pkg::ACT_SET_PAUSE: begin
        if (!(have_desired && pause_request == desired_pause)) begin
          desired_pause_next = pause_request;
          have_desired_next  = 1'b1;
          deadline_next      = now_ms;
        end
      end
      dscq_pkg::ACT_SNAPSHOT, dscq_pkg::ACT_SELECT_NOW: begin
        // Clear chatter history and force a re-apply at the event time
        chatter_flag_next     = 1'b0;
        have_last_next        = 1'b0;
        have_previous_next    = 1'b0;
        desired_bank_next     = bank_code;
        desired_position_next = dial_position;
        if (action == dscq_pkg::ACT_SNAPSHOT) begin
          desired_pause_next = pause_request;
        end else begin
          force_restart_next = 1'b1;
        end
        have_desired_next = 1'b1;
        deadline_next     = now_ms;
        have_applied_next = 1'b0;
      end
      dscq_pkg::ACT_TICK: begin
        if (pending_now && deadline_passed) begin
          applied_bank_next     = desired_bank;
          applied_position_next = desired_position;
          applied_pause_next    = desired_pause;
          have_applied_next     = 1'b1;
          apply_count_next      = apply_count + 32'd1;
          force_restart_next    = 1'b0;
          applied_flag          = 1'b1;
        end
      end
      default: ;  // unused codes leave the state alone
    endcase

    result_next.applied_now    = applied_flag;
    result_next.out_bank       = applied_bank_next;
    result_next.out_position   = applied_position_next;
    result_next.out_paused     = applied_pause_next;
    result_next.tuned          = have_applied_next;
    result_next.restart_forced = force_restart_next;
    result_next.chatter_active = chatter_flag_next;
    result_next.settling       = have_desired_next &&
                                 (!have_applied_next ||
                                  desired_bank_next != applied_bank_next ||
                                  desired_position_next != applied_position_next ||
                                  desired_pause_next != applied_pause_next);
    result_next.apply_total    = apply_count_next;
    result_next.ignored_total  = ignore_count_next;
    result_next.reading_total  = reading_count_next;
  end

  // ---------------------------------------------------------------------------
  // State registers: advance on every accepted word
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      have_desired      <= 1'b0;
      desired_bank      <= '0;
      desired_position  <= '0;
      desired_pause     <= 1'b0;
      have_applied      <= 1'b0;
      applied_bank      <= '0;
      applied_position  <= '0;
      applied_pause     <= 1'b0;
      deadline          <= '0;
      have_reading_time <= 1'b0;
      last_reading_time <= '0;
      have_last         <= 1'b0;
      have_previous     <= 1'b0;
      last_position     <= '0;
      previous_position <= '0;
      chatter_flag      <= 1'b0;
      pair_low          <= '0;
      pair_high         <= '0;
      force_restart     <= 1'b0;
      apply_count       <= '0;
      ignore_count      <= '0;
      reading_count     <= '0;
    end else if (accept) begin
      have_desired      <= have_desired_next;
      desired_bank      <= desired_bank_next;
      desired_position  <= desired_position_next;
      desired_pause     <= desired_pause_next;
      have_applied      <= have_applied_next;
      applied_bank      <= applied_bank_next;
      applied_position  <= applied_position_next;
      applied_pause     <= applied_pause_next;
      deadline          <= deadline_next;
      have_reading_time <= have_reading_time_next;
      last_reading_time <= last_reading_time_next;
      have_last         <= have_last_next;
      have_previous     <= have_previous_next;
      last_position     <= last_position_next;
      previous_position <= previous_position_next;
      chatter_flag      <= chatter_flag_next;
      pair_low          <= pair_low_next;
      pair_high         <= pair_high_next;
      force_restart     <= force_restart_next;
      apply_count       <= apply_count_next;
      ignore_count      <= ignore_count_next;
      reading_count     <= reading_count_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: load on accept, hold while the output side stalls
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(dscq_pkg::OutDataWidth - $bits(dscq_pkg::result_t)){1'b0}}, result};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // A word that applied the setting leaves nothing settling and reports tuned
  a_apply_settles: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result.applied_now) |-> (!result.settling && result.tuned))
    else $error("applied word still reports settling");

  // The apply counter moves only on an accepted tick that applies
  a_apply_count: assert property (@(posedge clk) disable iff (rst)
    !(accept && applied_flag) |=> (apply_count == $past(apply_count)))
    else $error("apply counter moved without an apply");

  // A latched chatter pair is ordered
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    chatter_flag |-> (pair_low <= pair_high))
    else $error("chatter pair out of order");

  // A pending restart always waits for an apply
  a_restart_unapplied: assert property (@(posedge clk) disable iff (rst)
    force_restart |-> !have_applied)
    else $error("restart pending while setting is applied");

  // Ignored readings are always counted as readings too
  a_ignore_counts: assert property (@(posedge clk) disable iff (rst)
    (ignore_count != $past(ignore_count)) |->
      (reading_count == $past(reading_count) + 32'd1))
    else $error("ignored reading not counted");

endmodule
